/* design/pcsb_pkg.sv */
// ----------------------------------------------------------------------------
// pcsb_pkg: shared types and constants for the scan binner
// Payload structs, status codes, register indexes, the controller to
// datapath command and status bundles, and the arctangent step table.
// ----------------------------------------------------------------------------
package pcsb_pkg;

  localparam int NUM_BINS      = 1024;
  localparam int CLIFF_NEAR_MM = 0;
  localparam int CLIFF_FAR_MM  = 65535;
  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int RB_W  = (BIN_W > 10) ? BIN_W : 10;

  // iterative unit sizes
  localparam int SQ_IN_W    = 56;
  localparam int SQ_ROOT_W  = 28;
  localparam int SQ_REM_W   = 31;
  localparam int DIV_W      = 28;
  localparam int CORD_STEPS = 14;
  localparam int CORD_W     = 27;
  localparam int ANG_W      = 17;
  localparam int STEP_W     = 5;

  // register indexes
  localparam logic [2:0] CFG_CAMERA_HEIGHT = 3'd0;
  localparam logic [2:0] CFG_GROUND_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT_LOW    = 3'd2;
  localparam logic [2:0] CFG_HEIGHT_HIGH   = 3'd3;
  localparam logic [2:0] CFG_NEAR_LIMIT    = 3'd4;
  localparam logic [2:0] CFG_FAR_LIMIT     = 3'd5;
  localparam logic [2:0] CFG_START_ANGLE   = 3'd6;
  localparam logic [2:0] CFG_ANGLE_STEP    = 3'd7;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_READ       = 3'd0,
    ST_CLOSER     = 3'd1,
    ST_NOT_CLOSER = 3'd2,
    ST_HEIGHT_REJ = 3'd3,
    ST_RANGE_REJ  = 3'd4,
    ST_ANGLE_REJ  = 3'd5
  } bin_status_t;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic [9:0]        read_bin;
  } in_item_t;

  typedef struct packed {
    bin_status_t status;
    logic [9:0]  bin;
    logic [15:0] range_mm;
  } out_item_t;

  typedef enum logic [1:0] {ADDR_CLR, ADDR_READ, ADDR_IDX} mem_addr_sel_t;
  typedef enum logic [2:0] {RNG_ZERO, RNG_MAX, RNG_ROOT, RNG_QUOT, RNG_KEEP, RNG_MEM} rng_sel_t;
  typedef enum logic [1:0] {BSEL_ZERO, BSEL_READ, BSEL_IDX} bin_sel_t;

  typedef struct packed {
    logic              capture;
    logic              sq_load;
    logic              sq_step;
    logic              div_ld_rng;
    logic              div_ld_bin;
    logic              div_step;
    logic              cord_load;
    logic              cord_step;
    logic [STEP_W-1:0] step;
    logic              mem_rd;
    logic              mem_we;
    mem_addr_sel_t     addr_sel;
    logic              wr_empty;
    logic [BIN_W-1:0]  clr_addr;
    logic              idx_load;
    logic              res_we;
    bin_status_t       res_status;
    rng_sel_t          res_rng;
    bin_sel_t          res_bin;
    logic              out_load;
  } pcsb_cmd_t;

  typedef struct packed {
    logic is_read;
    logic height_rej;
    logic zero_z;
    logic cliff;
    logic lim_rej;
    logic ang_rej;
    logic closer;
  } pcsb_sts_t;

  // atan(2^-i) in rad*8192
  function automatic logic signed [ANG_W-1:0] cordic_angle(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 17'sd6434;
      5'd1:    a = 17'sd3798;
      5'd2:    a = 17'sd2007;
      5'd3:    a = 17'sd1019;
      5'd4:    a = 17'sd511;
      5'd5:    a = 17'sd256;
      5'd6:    a = 17'sd128;
      5'd7:    a = 17'sd64;
      5'd8:    a = 17'sd32;
      5'd9:    a = 17'sd16;
      5'd10:   a = 17'sd8;
      5'd11:   a = 17'sd4;
      5'd12:   a = 17'sd2;
      5'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

endpackage

/* design/pcsb_dp.sv */
// ----------------------------------------------------------------------------
// pcsb_dp: scan binner datapath
// Config registers, squares, bit-serial square root and divider, CORDIC
// vectoring unit, bin memory, result and output registers.
// ----------------------------------------------------------------------------
module pcsb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pcsb_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  pcsb_pkg::pcsb_cmd_t cmd_i,
  output pcsb_pkg::pcsb_sts_t sts_o,
  output pcsb_pkg::out_item_t out_data
);
  import pcsb_pkg::*;

  // config
  logic [11:0]        cam_h_r;
  logic signed [15:0] gnd_r, hlo_r, hhi_r, sang_r;
  logic [15:0]        near_r, far_r, astep_r;

  in_item_t           in_r;
  logic signed [15:0] x_s, y_s, z_s;
  logic [15:0]        az;

  logic signed [31:0] xsq, ysq;
  logic [31:0]        xx_r, yy_r, s_r;
  logic [23:0]        ch2_r;
  logic [55:0]        h2s_r;

  // square root
  logic [SQ_IN_W-1:0]   sq_n_r;
  logic [SQ_ROOT_W-1:0] sq_root_r;
  logic [SQ_REM_W-1:0]  sq_rem_r;
  logic [SQ_REM_W-1:0]  sq_sh, sq_trial;
  logic                 sq_ge;

  // divider
  logic [DIV_W-1:0] div_n_r;
  logic [15:0]      div_rem_r, div_d_r;
  logic [16:0]      div_t;
  logic             div_ge;
  logic [15:0]      quot16, root16;
  logic [BIN_W-1:0] qidx, idx_r;

  // cordic
  logic signed [CORD_W-1:0] cx_r, cy_r, xs, ys, cdx, cdy;
  logic signed [ANG_W-1:0]  acc_r, theta;
  logic                     azero_r;
  logic signed [17:0]       diff;
  logic [15:0]              step_eff;
  logic [31:0]              span;

  // limits
  logic [33:0] cl_lo, cl_hi, root34;
  logic        lim_obs, lim_cliff, rem_nz;

  // memory and results
  logic [15:0]      mem [NUM_BINS];
  logic [15:0]      mem_rd_r;
  logic [BIN_W-1:0] mem_addr;
  logic [RB_W-1:0]  rb_wide;
  logic             rb_ok;
  bin_status_t      res_status_r;
  logic [9:0]       res_bin_r;
  logic [15:0]      res_range_r;
  out_item_t        out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_h_r <= '0;
      gnd_r   <= '0;
      hlo_r   <= '0;
      hhi_r   <= '0;
      near_r  <= '0;
      far_r   <= 16'd46341;
      sang_r  <= -16'sd25736;
      astep_r <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAMERA_HEIGHT: cam_h_r <= cfg_wdata[11:0];
        CFG_GROUND_LEVEL:  gnd_r   <= cfg_wdata;
        CFG_HEIGHT_LOW:    hlo_r   <= cfg_wdata;
        CFG_HEIGHT_HIGH:   hhi_r   <= cfg_wdata;
        CFG_NEAR_LIMIT:    near_r  <= cfg_wdata;
        CFG_FAR_LIMIT:     far_r   <= cfg_wdata;
        CFG_START_ANGLE:   sang_r  <= cfg_wdata;
        CFG_ANGLE_STEP:    astep_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign x_s = in_r.x_mm;
  assign y_s = in_r.y_mm;
  assign z_s = in_r.z_mm;
  assign az  = z_s[15] ? 16'(~z_s + 16'sd1) : z_s;

  assign xsq = x_s * x_s;
  assign ysq = y_s * y_s;

  // free-running product chain, the controller waits it out
  always_ff @(posedge clk) begin
    if (cmd_i.capture) in_r <= in_data;
    xx_r  <= $unsigned(xsq);
    yy_r  <= $unsigned(ysq);
    s_r   <= xx_r + yy_r;
    ch2_r <= cam_h_r * cam_h_r;
    h2s_r <= 56'(ch2_r) * 56'(s_r);
  end

  // square root, one result bit a step
  assign sq_sh    = {sq_rem_r[SQ_REM_W-3:0], sq_n_r[SQ_IN_W-1 -: 2]};
  assign sq_trial = SQ_REM_W'({sq_root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;

  always_ff @(posedge clk) begin
    if (cmd_i.sq_load) begin
      sq_n_r    <= (z_s < gnd_r) ? h2s_r : SQ_IN_W'(s_r);
      sq_root_r <= '0;
      sq_rem_r  <= '0;
    end else if (cmd_i.sq_step) begin
      sq_n_r    <= {sq_n_r[SQ_IN_W-3:0], 2'b00};
      sq_root_r <= {sq_root_r[SQ_ROOT_W-2:0], sq_ge};
      sq_rem_r  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
    end
  end

  // restoring divider
  assign div_t  = {div_rem_r, div_n_r[DIV_W-1]};
  assign div_ge = div_t >= {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (cmd_i.div_ld_rng) begin
      div_n_r   <= DIV_W'(sq_root_r);
      div_d_r   <= az;
      div_rem_r <= '0;
    end else if (cmd_i.div_ld_bin) begin
      div_n_r   <= DIV_W'(diff[16:0]);
      div_d_r   <= step_eff;
      div_rem_r <= '0;
    end else if (cmd_i.div_step) begin
      div_n_r   <= {div_n_r[DIV_W-2:0], div_ge};
      div_rem_r <= div_ge ? 16'(div_t - {1'b0, div_d_r}) : div_t[15:0];
    end
  end

  assign quot16 = (|div_n_r[DIV_W-1:16]) ? 16'hFFFF : div_n_r[15:0];
  assign root16 = (|sq_root_r[SQ_ROOT_W-1:16]) ? 16'hFFFF : sq_root_r[15:0];
  assign qidx   = (div_n_r > DIV_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                   : div_n_r[BIN_W-1:0];

  // cordic vectoring
  assign xs  = {{3{x_s[15]}}, x_s, 8'b0};
  assign ys  = {{3{y_s[15]}}, y_s, 8'b0};
  assign cdx = cy_r >>> cmd_i.step;
  assign cdy = cx_r >>> cmd_i.step;

  always_ff @(posedge clk) begin
    if (cmd_i.cord_load) begin
      azero_r <= (x_s == 16'sd0) && (y_s == 16'sd0);
      if (x_s[15]) begin
        if (!y_s[15]) begin
          cx_r  <= ys;
          cy_r  <= -xs;
          acc_r <= 17'sd12868;
        end else begin
          cx_r  <= -ys;
          cy_r  <= xs;
          acc_r <= -17'sd12868;
        end
      end else begin
        cx_r  <= xs;
        cy_r  <= ys;
        acc_r <= '0;
      end
    end else if (cmd_i.cord_step) begin
      if (cy_r > 0) begin
        cx_r  <= cx_r + cdx;
        cy_r  <= cy_r - cdy;
        acc_r <= acc_r + cordic_angle(cmd_i.step);
      end else begin
        cx_r  <= cx_r - cdx;
        cy_r  <= cy_r + cdy;
        acc_r <= acc_r - cordic_angle(cmd_i.step);
      end
    end
  end

  assign theta    = azero_r ? '0 : acc_r;
  assign diff     = 18'(theta) - 18'(sang_r);
  assign step_eff = (astep_r == 16'd0) ? 16'd1 : astep_r;
  assign span     = 32'(NUM_BINS) * 32'(step_eff);

  // range limits, exact via root and remainder
  assign rem_nz    = |sq_rem_r;
  assign root34    = 34'(sq_root_r);
  assign cl_lo     = 34'(CLIFF_NEAR_MM) * 34'(az);
  assign cl_hi     = 34'(CLIFF_FAR_MM) * 34'(az);
  assign lim_cliff = (root34 < cl_lo) || (root34 > cl_hi) || ((root34 == cl_hi) && rem_nz);
  assign lim_obs   = (sq_root_r < SQ_ROOT_W'(near_r)) || (sq_root_r > SQ_ROOT_W'(far_r)) ||
                     ((sq_root_r == SQ_ROOT_W'(far_r)) && rem_nz);

  // bin memory
  assign rb_wide = RB_W'(in_r.read_bin);
  assign rb_ok   = 32'(in_r.read_bin) < NUM_BINS;

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CLR:  mem_addr = cmd_i.clr_addr;
      ADDR_READ: mem_addr = rb_wide[BIN_W-1:0];
      ADDR_IDX:  mem_addr = idx_r;
      default:   mem_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.mem_we && (cmd_i.addr_sel != ADDR_READ || rb_ok))
      mem[mem_addr] <= cmd_i.wr_empty ? EMPTY_MARK : res_range_r;
    if (cmd_i.mem_rd)
      mem_rd_r <= mem[mem_addr];
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd_i.idx_load) idx_r <= qidx;
    if (cmd_i.res_we) begin
      res_status_r <= cmd_i.res_status;
      case (cmd_i.res_bin)
        BSEL_ZERO: res_bin_r <= '0;
        BSEL_READ: res_bin_r <= in_r.read_bin;
        BSEL_IDX:  res_bin_r <= 10'(idx_r);
        default:   res_bin_r <= '0;
      endcase
      case (cmd_i.res_rng)
        RNG_ZERO: res_range_r <= '0;
        RNG_MAX:  res_range_r <= 16'hFFFF;
        RNG_ROOT: res_range_r <= root16;
        RNG_QUOT: res_range_r <= quot16;
        RNG_KEEP: res_range_r <= res_range_r;
        RNG_MEM:  res_range_r <= rb_ok ? mem_rd_r : EMPTY_MARK;
        default:  res_range_r <= res_range_r;
      endcase
    end
    if (cmd_i.out_load) begin
      out_r.status   <= res_status_r;
      out_r.bin      <= res_bin_r;
      out_r.range_mm <= res_range_r;
    end
  end

  assign out_data = out_r;

  always_comb begin
    sts_o.is_read    = in_r.operation == OP_READ;
    sts_o.height_rej = ((z_s > gnd_r) && (z_s < hlo_r)) || (z_s > hhi_r) ||
                       ((z_s < gnd_r) && (cam_h_r == 12'd0));
    sts_o.cliff      = z_s < gnd_r;
    sts_o.zero_z     = (z_s < gnd_r) && (z_s == 16'sd0);
    sts_o.lim_rej    = (z_s < gnd_r) ? lim_cliff : lim_obs;
    sts_o.ang_rej    = diff[17] || (32'(diff[16:0]) > span);
    sts_o.closer     = res_range_r < mem_rd_r;
  end

  a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div_ld_rng |-> az != 16'd0) else $error("range divide by zero height");
  a_bin_inside : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div_ld_bin |-> !diff[17]) else $error("bin divide on negative offset");
  a_store_closer : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.res_we && cmd_i.res_status == ST_CLOSER) |-> (res_range_r < mem_rd_r))
    else $error("closer status without smaller range");

endmodule

/* design/pcsb_ctrl.sv */
// ----------------------------------------------------------------------------
// pcsb_ctrl: scan binner controller
// Sequences the memory clear, the point pipeline steps and the output
// register handoff.
// ----------------------------------------------------------------------------
module pcsb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pcsb_pkg::pcsb_sts_t sts_i,
  output pcsb_pkg::pcsb_cmd_t cmd_o
);
  import pcsb_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SUM, S_MUL, S_SQLD, S_SQRT, S_LIM, S_DIVR,
    S_RNG, S_CLD, S_CORD, S_ANG, S_DIVB, S_BIDX, S_MRD, S_CMP, S_RDDONE, S_OUT
  } state_t;

  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(SQ_ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
  localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORD_STEPS - 1);
  localparam logic [BIN_W-1:0]  CLR_LAST  = BIN_W'(NUM_BINS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [BIN_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd_o       = '0;
    cmd_o.step     = cnt_r;
    cmd_o.clr_addr = clr_cnt_r;
    cmd_o.addr_sel = ADDR_IDX;
    cmd_o.res_status = ST_READ;
    cmd_o.res_rng  = RNG_KEEP;
    cmd_o.res_bin  = BSEL_ZERO;

    case (state_r)
      S_CLEAR: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wr_empty = 1'b1;
        cmd_o.addr_sel = ADDR_CLR;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.addr_sel = ADDR_READ;
        if (sts_i.is_read) begin
          cmd_o.mem_rd = 1'b1;
          state_nxt    = S_RDDONE;
        end else if (sts_i.height_rej) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_HEIGHT_REJ;
          cmd_o.res_rng    = RNG_ZERO;
          state_nxt        = S_OUT;
        end else if (sts_i.zero_z) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_RANGE_REJ;
          cmd_o.res_rng    = RNG_MAX;
          state_nxt        = S_OUT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: state_nxt = S_MUL;
      S_MUL: state_nxt = S_SQLD;
      S_SQLD: begin
        cmd_o.sq_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) state_nxt = S_LIM;
      end
      S_LIM: begin
        if (sts_i.cliff) begin
          cmd_o.div_ld_rng = 1'b1;
          cnt_nxt          = '0;
          state_nxt        = S_DIVR;
        end else begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_rng    = RNG_ROOT;
          cmd_o.res_status = ST_RANGE_REJ;
          state_nxt        = sts_i.lim_rej ? S_OUT : S_CLD;
        end
      end
      S_DIVR: begin
        cmd_o.div_step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_RNG;
      end
      S_RNG: begin
        cmd_o.res_we     = 1'b1;
        cmd_o.res_rng    = RNG_QUOT;
        cmd_o.res_status = ST_RANGE_REJ;
        state_nxt        = sts_i.lim_rej ? S_OUT : S_CLD;
      end
      S_CLD: begin
        cmd_o.cord_load = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_CORD;
      end
      S_CORD: begin
        cmd_o.cord_step = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CORD_LAST) state_nxt = S_ANG;
      end
      S_ANG: begin
        if (sts_i.ang_rej) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_ANGLE_REJ;
          state_nxt        = S_OUT;
        end else begin
          cmd_o.div_ld_bin = 1'b1;
          cnt_nxt          = '0;
          state_nxt        = S_DIVB;
        end
      end
      S_DIVB: begin
        cmd_o.div_step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_BIDX;
      end
      S_BIDX: begin
        cmd_o.idx_load = 1'b1;
        state_nxt      = S_MRD;
      end
      S_MRD: begin
        cmd_o.mem_rd = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd_o.res_we     = 1'b1;
        cmd_o.res_bin    = BSEL_IDX;
        cmd_o.res_status = sts_i.closer ? ST_CLOSER : ST_NOT_CLOSER;
        cmd_o.mem_we     = sts_i.closer;
        state_nxt        = S_OUT;
      end
      S_RDDONE: begin
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = ST_READ;
        cmd_o.res_rng    = RNG_MEM;
        cmd_o.res_bin    = BSEL_READ;
        cmd_o.addr_sel   = ADDR_READ;
        cmd_o.mem_we     = 1'b1;
        cmd_o.wr_empty   = 1'b1;
        state_nxt        = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || cmd_o.out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> (!out_valid_r || !out_stall)) else $error("output overwritten");
  a_accept_decode : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DECODE) else $error("accept without decode");
  a_sqrt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> cnt_r <= SQ_LAST) else $error("root step count overrun");

endmodule

/* design/point_cloud_to_scan_binner.sv */
// ----------------------------------------------------------------------------
// point_cloud_to_scan_binner: folds 3D points into a ring of angular bins
// Each bin keeps the smallest planar range seen since its last read.
// ----------------------------------------------------------------------------
//
//   port group | dir | transfer when        | payload
//   -----------+-----+----------------------+----------------------------
//   in_        | in  | in_valid & !in_stall | in_item_t (op, x, y, z, bin)
//   out_       | out | out_valid & !out_stall | out_item_t (status, bin, range)
//   cfg_       | in  | cfg_we               | index 0..7, 16-bit data
//
// - one item at a time; the time a point takes is set by the
//   one-bit-per-cycle square root (28 steps), the shared restoring divider
//   (28 steps each use, twice for a cliff point, once for an obstacle
//   point) and 14 cordic steps; a read uses none of these units
// - after reset a pass writes the empty mark into every bin;
//   in_stall stays high meanwhile, config writes are taken as usual
// - a finished result waits in the output register; the next item is taken
//   while it waits, and only the final handoff holds for out_stall
module point_cloud_to_scan_binner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcsb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcsb_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import pcsb_pkg::*;

  // command and status between sequencer and datapath
  pcsb_cmd_t cmd;
  pcsb_sts_t sts;

  pcsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // range, angle and bin memory work
  pcsb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data  (out_data)
  );

endmodule
